// ===== rtl/core/pert_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pert_pkg
// shared types and constants of the pending event reissue table
// ----------------------------------------------------------------------------
package pert_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = 64;
	localparam logic [15:0] DEFAULT_INTERVAL_RST = 16'd60;
	localparam logic [15:0] WAIT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		FN_REG   = 2'd0,
		FN_DEREG = 2'd1,
		FN_TICK  = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UPDATED   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_QREAD,
		S_QLOAD,
		S_OWAIT,
		S_CLOAD,
		S_CWAIT
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] ivl;
		logic [31:0] last;
	} entry_t;

	typedef struct packed {
		logic        live;
		logic        due;
		logic [15:0] best;
	} eval_t;

endpackage
`default_nettype wire

// ===== rtl/core/pert_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pert_if
// handshake channels of the pending event reissue table
// ----------------------------------------------------------------------------
interface pert_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] event_id;
	logic [15:0] interval;
	logic [31:0] now;
	modport source (output valid, func, event_id, interval, now, input ready);
	modport sink   (input valid, func, event_id, interval, now, output ready);
endinterface

interface pert_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] event_id_out;
	logic [1:0]  status;
	logic [15:0] sleep_time;
	logic        last;
	modport source (output valid, kind, event_id_out, status, sleep_time, last,
		input ready);
	modport sink   (input valid, kind, event_id_out, status, sleep_time, last,
		output ready);
endinterface

interface pert_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pert_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pert_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pert_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/pert_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pert_eval
// due check of one table entry against the tick time, running minimum
// ----------------------------------------------------------------------------
module pert_eval (
	input  wire logic          valid,
	input  wire pert_pkg::entry_t ent,
	input  wire logic [31:0]   now,
	input  wire logic [15:0]   best,
	output pert_pkg::eval_t    res
);
	import pert_pkg::*;

	logic [32:0] due_at;
	logic [32:0] rem;

	always_comb begin
		due_at   = {1'b0, ent.last} + {17'd0, ent.ivl};
		rem      = due_at - {1'b0, now};
		res.live = valid && (ent.last < now);
		res.due  = (due_at <= {1'b0, now});
		res.best = best;
		if (res.live) begin
			if (res.due) begin
				if (ent.ivl < best) res.best = ent.ivl;
			end else if (rem < {17'd0, best}) begin
				res.best = rem[15:0];
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/pending_event_reissue_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pending_event_reissue_table
// table of pending events with register, deregister and a periodic reissue
// scan driven by a one-second tick
// ----------------------------------------------------------------------------
//   channel  dir  word
//   cfg      in   default reissue interval
//   req      in   func, event_id, interval, now
//   rsp      out  kind, event_id_out, status, sleep_time, last
//
// one request at a time. register, deregister and a due tick walk all
// TABLE_DEPTH slots through the entry ram, one read a cycle, then wait for the
// last slot's data, close the walk and run the update; each issued word goes
// through a queue ram read, a load and a handshake, and the completion through
// a load and a handshake. a tick that is not due skips the walk. reset clears
// the valid bits, the counters and the control; the rams need no clearing.
// output stalls simply hold the block.
// ----------------------------------------------------------------------------
module pending_event_reissue_table (
	input wire logic clk,
	input wire logic arst_n,
	pert_cfg_if.sink   cfg,
	pert_req_if.sink   req,
	pert_rsp_if.source rsp
);
	import pert_pkg::*;

	state_t state_q, state_d;

	// configuration and sleep bookkeeping
	logic [15:0] default_q;
	logic [15:0] sleep_q;
	logic [15:0] waited_q;
	logic [15:0] best_q;

	// latched request
	func_t       func_q;
	logic [15:0] id_q;
	logic [15:0] ivl_q;
	logic [31:0] now_q;
	logic        due_q;

	// slot walk
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] idx_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] match_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// issued word queue
	logic [CNT_W-1:0] qn_q;
	logic [CNT_W-1:0] qi_q;

	status_t status_q;

	// output register
	logic        o_valid_q;
	logic        o_kind_q;
	logic [15:0] o_id_q;
	logic [1:0]  o_status_q;
	logic        o_last_q;

	// ram ports
	logic             t_we;
	logic [IDX_W-1:0] t_waddr;
	entry_t           t_wdata;
	entry_t           t_rdata;
	logic             q_we;
	logic [15:0]      q_wdata;
	logic [15:0]      q_rdata;

	eval_t ev;
	logic  e_valid;
	logic  walk_done;
	logic [15:0] ivl_eff;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid        = o_valid_q;
	assign rsp.kind         = o_kind_q;
	assign rsp.event_id_out = o_id_q;
	assign rsp.status       = o_status_q;
	assign rsp.sleep_time   = sleep_q;
	assign rsp.last         = o_last_q;

	assign e_valid   = valid_q[rd_idx_s1];
	assign walk_done = (idx_q == CNT_W'(TABLE_DEPTH)) && !rd_v_s1;
	assign ivl_eff   = (ivl_q == 16'd0) ? default_q : ivl_q;

	pert_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (t_rdata)
	);

	pert_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (qn_q[IDX_W-1:0]),
		.wdata (q_wdata),
		.raddr (qi_q[IDX_W-1:0]),
		.rdata (q_rdata)
	);

	pert_eval u_eval (
		.valid (e_valid),
		.ent   (t_rdata),
		.now   (now_q),
		.best  (best_q),
		.res   (ev)
	);

	// write strobes of both rams
	always_comb begin
		t_we    = 1'b0;
		t_waddr = rd_idx_s1;
		t_wdata = t_rdata;
		q_we    = 1'b0;
		q_wdata = t_rdata.id;
		if (state_q == S_SCAN && rd_v_s1 && func_q == FN_TICK && ev.live && ev.due)
		begin
			// reissue: stamp the entry and queue its id
			t_we         = 1'b1;
			t_wdata.last = now_q;
			q_we         = 1'b1;
		end else if (state_q == S_UPDATE && func_q == FN_REG && (found_q || free_q))
		begin
			t_we    = 1'b1;
			t_waddr = found_q ? match_q : free_idx_q;
			t_wdata = '{id: id_q, ivl: ivl_eff, last: now_q};
			q_we    = 1'b1;
			q_wdata = id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.func == FN_REG || req.func == FN_DEREG ||
						(req.func == FN_TICK && sleep_q <= waited_q))
						state_d = S_SCAN;
					else
						state_d = S_UPDATE;
				end
			end
			S_SCAN:   if (walk_done) state_d = S_UPDATE;
			S_UPDATE: state_d = (q_we || qn_q != '0) ? S_QREAD : S_CLOAD;
			S_QREAD:  state_d = S_QLOAD;
			S_QLOAD:  state_d = S_OWAIT;
			S_OWAIT: begin
				if (rsp.ready) state_d = (qi_q + 1'b1 == qn_q) ? S_CLOAD : S_QREAD;
			end
			S_CLOAD:  state_d = S_CWAIT;
			S_CWAIT:  if (rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= DEFAULT_INTERVAL_RST;
			sleep_q   <= DEFAULT_INTERVAL_RST;
			waited_q  <= '0;
			valid_q   <= '0;
			idx_q     <= '0;
			rd_v_s1   <= 1'b0;
			qn_q      <= '0;
			qi_q      <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) default_q <= cfg.data;
			if (q_we) qn_q <= qn_q + 1'b1;
			rd_v_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					qn_q  <= '0;
					qi_q  <= '0;
					if (req.valid && req.func == FN_TICK) begin
						if (sleep_q <= waited_q) waited_q <= '0;
						else if (waited_q != WAIT_MAX) waited_q <= waited_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (idx_q != CNT_W'(TABLE_DEPTH)) begin
						idx_q   <= idx_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end
				end
				S_UPDATE: begin
					if (func_q == FN_REG && (found_q || free_q)) begin
						valid_q[found_q ? match_q : free_idx_q] <= 1'b1;
						if (sleep_q > ivl_eff) sleep_q <= ivl_eff;
					end
					if (func_q == FN_DEREG && found_q) valid_q[match_q] <= 1'b0;
					if (func_q == FN_TICK && due_q) sleep_q <= best_q;
				end
				S_QLOAD: o_valid_q <= 1'b1;
				S_OWAIT: begin
					if (rsp.ready) begin
						o_valid_q <= 1'b0;
						qi_q      <= qi_q + 1'b1;
					end
				end
				S_CLOAD: o_valid_q <= 1'b1;
				S_CWAIT: if (rsp.ready) o_valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			rd_idx_s1 <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			if (req.valid) begin
				func_q <= func_t'(req.func);
				id_q   <= req.event_id;
				ivl_q  <= req.interval;
				now_q  <= req.now;
				due_q  <= (sleep_q <= waited_q);
				best_q <= default_q;
			end
		end
		if (state_q == S_SCAN) begin
			rd_idx_s1 <= idx_q[IDX_W-1:0];
			if (rd_v_s1) begin
				// first live match and first free slot, in slot order
				if (e_valid && t_rdata.id == id_q && !found_q) begin
					found_q <= 1'b1;
					match_q <= rd_idx_s1;
				end
				if (!e_valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
				if (func_q == FN_TICK) best_q <= ev.best;
			end
		end
		if (state_q == S_UPDATE) begin
			case (func_q)
				FN_REG:   status_q <= found_q ? ST_UPDATED : (free_q ? ST_OK : ST_FULL);
				FN_DEREG: status_q <= found_q ? ST_OK : ST_NOT_FOUND;
				default:  status_q <= ST_OK;
			endcase
		end
		if (state_q == S_QLOAD) begin
			o_kind_q   <= 1'b0;
			o_id_q     <= q_rdata;
			o_status_q <= ST_OK;
			o_last_q   <= 1'b0;
		end
		if (state_q == S_CLOAD) begin
			o_kind_q   <= 1'b1;
			o_id_q     <= '0;
			o_status_q <= status_q;
			o_last_q   <= 1'b1;
		end
	end
endmodule
`default_nettype wire
